FILE: src/utt_pkg.sv
// shared types, constants and helpers for the utf16/utf32 to utf-8 transcoder
package utt_pkg;

	localparam int UTT_QUEUE_DEPTH = 4;

	localparam logic [2:0] ORD_RAW     = 3'd0;
	localparam logic [2:0] ORD_UTF8    = 3'd1;
	localparam logic [2:0] ORD_UTF16LE = 3'd2;
	localparam logic [2:0] ORD_UTF16BE = 3'd3;
	localparam logic [2:0] ORD_UTF32LE = 3'd4;
	localparam logic [2:0] ORD_UTF32BE = 3'd5;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_LEAD    = 2'd1;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

	localparam int MAX_CHAR_BYTES = 6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       char_end;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		logic [MAX_CHAR_BYTES-1:0][7:0] bytes;
		logic [2:0]                     cnt;
		logic [1:0]                     status;
	} char_desc_t;

	function automatic logic [2:0] utf8_len(input logic [7:0] lead);
		logic [2:0] n;
		priority if (lead[7] == 1'b0)            n = 3'd1;
		else if ((lead & 8'he0) == 8'hc0)        n = 3'd2;
		else if ((lead & 8'hf0) == 8'he0)        n = 3'd3;
		else if ((lead & 8'hf8) == 8'hf0)        n = 3'd4;
		else if ((lead & 8'hfc) == 8'hf8)        n = 3'd5;
		else if ((lead & 8'hfe) == 8'hfc)        n = 3'd6;
		else                                     n = 3'd0;
		return n;
	endfunction

endpackage

FILE: src/utf16_utf32_to_utf8_transcoder_unit.sv
// top level of the utf16/utf32 to utf-8 transcoder
// usage:
//  input side is a queue: drive item and raise push; the word is taken at a
//  clock edge where push is high and full is low. stream_end drops a partial
//  character and produces nothing
//  output side is a queue: while empty is low, result holds the oldest utf-8
//  byte; raising pop takes it. char_end marks the last byte of a character
//  the user writes the mode register via cfg_wr_en / cfg_wr_data only while
//  the block is idle (not enforced); a write drops any partial character
//  one input word is taken per cycle while full is low; a character's bytes
//  come out one per cycle while the receiver keeps popping, so the output
//  side sets the sustained rate (up to six bytes for a long utf-8 sequence,
//  up to three for utf-16/utf-32); the word that completes a character
//  reaches the output through the descriptor queue, then the output register
//  when the receiver stalls, the descriptor queue (QUEUE_DEPTH characters)
//  fills and full rises; nothing is lost
//  reset clears the queue and the output register and selects raw mode
module utf16_utf32_to_utf8_transcoder_unit import utt_pkg::*; #(
	parameter int QUEUE_DEPTH = UTT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       push,
	output logic       full,
	input  in_word_t   item,
	output logic       empty,
	input  logic       pop,
	output out_word_t  result
);

	logic       desc_push;
	char_desc_t desc;
	logic       desc_pop;
	char_desc_t head;
	logic       q_empty;
	logic       q_full;

	assign full = q_full;

	utt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.item        (item),
		.q_full      (q_full),
		.desc_push   (desc_push),
		.desc        (desc)
	);

	utt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (desc_push),
		.wr_data (desc),
		.rd      (desc_pop),
		.head    (head),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	utt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.desc_pop (desc_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		desc_push |-> !q_full)
		else $error("descriptor pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |-> !q_empty)
		else $error("descriptor popped from empty queue");

	a_end_gives_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.stream_end) |-> !desc_push)
		else $error("stream end produced a descriptor");

	a_head_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (head.cnt != 3'd0 && head.cnt <= 3'd6))
		else $error("queued descriptor has bad byte count");

endmodule

FILE: src/utt_front.sv
// front end: takes input words, gathers characters and builds output descriptors
module utt_front import utt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       push,
	input  in_word_t   item,
	input  logic       q_full,
	output logic       desc_push,
	output char_desc_t desc
);

	logic [2:0] order_q;
	logic [2:0] gcnt_q;
	logic [2:0] ecnt_q;
	logic [7:0] gb_q [MAX_CHAR_BYTES];

	logic                           accept;
	logic                           is_raw;
	logic                           is_utf8;
	logic [2:0]                     lead_n;
	logic [2:0]                     need;
	logic                           bad_lead;
	logic [2:0]                     gcnt_inc;
	logic                           done;
	logic [MAX_CHAR_BYTES-1:0][7:0] cur;
	logic [31:0]                    val;
	logic [15:0]                    v16;
	char_desc_t                     enc;

	assign accept   = push && !q_full;
	assign is_raw   = (order_q == ORD_RAW) || (order_q > ORD_UTF32BE);
	assign is_utf8  = (order_q == ORD_UTF8);
	assign lead_n   = utf8_len(item.in_byte);
	assign bad_lead = is_utf8 && (gcnt_q == 3'd0) && (lead_n == 3'd0);
	assign gcnt_inc = 3'(gcnt_q + 3'd1);
	assign done     = gcnt_inc >= need;

	always_comb begin
		if (gcnt_q != 3'd0) begin
			need = ecnt_q;
		end else if (is_utf8) begin
			need = lead_n;
		end else if (order_q <= ORD_UTF16BE) begin
			need = 3'd2;
		end else begin
			need = 3'd4;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_CHAR_BYTES; i++) begin
			cur[i] = (gcnt_q == 3'(i)) ? item.in_byte : gb_q[i];
		end
	end

	always_comb begin
		priority if (order_q == ORD_UTF16LE) begin
			val = {16'h0000, cur[1], cur[0]};
		end else if (order_q == ORD_UTF16BE) begin
			val = {16'h0000, cur[0], cur[1]};
		end else if (order_q == ORD_UTF32LE) begin
			val = {cur[3], cur[2], cur[1], cur[0]};
		end else begin
			val = {cur[0], cur[1], cur[2], cur[3]};
		end
	end

	assign v16 = val[15:0];

	// encode the gathered code unit as utf-8; a value above 16 bits is marked unsupported
	always_comb begin
		enc = '0;
		priority if (val[31:16] != 16'h0000) begin
			enc.cnt    = 3'd1;
			enc.status = ST_UNSUPPORTED;
		end else if (v16 < 16'h0080) begin
			enc.bytes[0] = {1'b0, v16[6:0]};
			enc.cnt      = 3'd1;
		end else if (v16 < 16'h0800) begin
			enc.bytes[0] = {3'b110, v16[10:6]};
			enc.bytes[1] = {2'b10, v16[5:0]};
			enc.cnt      = 3'd2;
		end else begin
			enc.bytes[0] = {4'b1110, v16[15:12]};
			enc.bytes[1] = {2'b10, v16[11:6]};
			enc.bytes[2] = {2'b10, v16[5:0]};
			enc.cnt      = 3'd3;
		end
	end

	always_comb begin
		desc      = '0;
		desc_push = 1'b0;
		if (accept && !item.stream_end) begin
			priority if (is_raw) begin
				desc_push     = 1'b1;
				desc.bytes[0] = item.in_byte;
				desc.cnt      = 3'd1;
				desc.status   = ST_OK;
			end else if (bad_lead) begin
				desc_push     = 1'b1;
				desc.bytes[0] = item.in_byte;
				desc.cnt      = 3'd1;
				desc.status   = ST_BAD_LEAD;
			end else if (done) begin
				desc_push = 1'b1;
				if (is_utf8) begin
					desc.bytes  = cur;
					desc.cnt    = need;
					desc.status = ST_OK;
				end else begin
					desc = enc;
				end
			end else begin
				desc_push = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_RAW;
			gcnt_q  <= 3'd0;
			ecnt_q  <= 3'd0;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
			gcnt_q  <= 3'd0;
			ecnt_q  <= 3'd0;
		end else if (accept) begin
			if (item.stream_end) begin
				gcnt_q <= 3'd0;
				ecnt_q <= 3'd0;
			end else if (!is_raw && !bad_lead) begin
				if (done) begin
					gcnt_q <= 3'd0;
					ecnt_q <= 3'd0;
				end else begin
					gcnt_q <= gcnt_inc;
					ecnt_q <= need;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !item.stream_end && !is_raw && !bad_lead && !done) begin
			gb_q[gcnt_q] <= item.in_byte;
		end
	end

endmodule

FILE: src/utt_queue.sv
// short descriptor queue between front and back ends
module utt_queue import utt_pkg::*; #(
	parameter int DEPTH = UTT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  char_desc_t wr_data,
	input  logic       rd,
	output char_desc_t head,
	output logic       q_empty,
	output logic       q_full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	char_desc_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_empty = (cnt_q == '0);
	assign q_full  = (cnt_q == CNT_W'(DEPTH));
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: src/utt_back.sv
// back end: unpacks descriptors into output words, one byte per cycle while the receiver keeps popping
module utt_back import utt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  char_desc_t head,
	input  logic       q_empty,
	output logic       desc_pop,
	input  logic       pop,
	output logic       empty,
	output out_word_t  result
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;
	logic       load;
	logic       last;

	assign load     = !q_empty && (!out_valid_q || pop);
	assign last     = (idx_q == 3'(head.cnt - 3'd1));
	assign desc_pop = load && last;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? 3'd0 : 3'(idx_q + 3'd1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head.bytes[idx_q];
			out_q.char_end <= last;
			out_q.status   <= head.status;
		end
	end

endmodule
